// ===== src/qau_pkg.sv =====
// Shared types, constants and fixed-point helpers for the quaternion unit.
// Depends on nothing; the front, normalize, back and top modules and the testbench import it.
package qau_pkg;

	// Fixed-point format of every operand and result component.
	localparam int DATA_W = 32;
	localparam int FRAC_W = 28;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = 2 * DATA_W + 4;
	localparam int NORM_W = 2 * DATA_W + 2;
	localparam int LANES  = 4;

	// Action codes on the request channel.
	localparam logic [2:0] ACT_ADD       = 3'd0;
	localparam logic [2:0] ACT_SUB       = 3'd1;
	localparam logic [2:0] ACT_SCALE     = 3'd2;
	localparam logic [2:0] ACT_MUL       = 3'd3;
	localparam logic [2:0] ACT_NORM2     = 3'd4;
	localparam logic [2:0] ACT_NORMALIZE = 3'd5;
	localparam logic [2:0] ACT_MATRIX    = 3'd6;

	// Status codes on the result channel.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	// Last matrix row index.
	localparam logic [1:0] ROW_LAST = 2'd2;

	typedef logic signed [DATA_W-1:0] qword_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_SCALE,
		OP_MUL,
		OP_NORM2,
		OP_NORMALIZE,
		OP_MATRIX,
		OP_NONE
	} qau_op_t;

	typedef struct packed {
		logic [2:0] action;
		qword_t     a_s;
		qword_t     a_x;
		qword_t     a_y;
		qword_t     a_z;
		qword_t     b_s;
		qword_t     b_x;
		qword_t     b_y;
		qword_t     b_z;
	} qau_req_t;

	typedef struct packed {
		qword_t     res_s;
		qword_t     res_x;
		qword_t     res_y;
		qword_t     res_z;
		logic [1:0] status;
		logic       last;
	} qau_res_t;

	// Classified request as it waits between the front and the back.
	typedef struct packed {
		qau_op_t                      op;
		logic [LANES-1:0][DATA_W-1:0] a;
		logic [LANES-1:0][DATA_W-1:0] b;
	} qau_item_t;

	typedef struct packed {
		logic   sat;
		qword_t val;
	} qau_lane_t;

	// Clamp a wide signed value to the data word range.
	function automatic qau_lane_t sat_word(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		qau_lane_t               r;
		hi = (ACC_W'(1) << (DATA_W - 1)) - ACC_W'(1);
		lo = ~hi;
		if (x > hi) begin
			r.sat = 1'b1;
			r.val = hi[DATA_W-1:0];
		end else if (x < lo) begin
			r.sat = 1'b1;
			r.val = lo[DATA_W-1:0];
		end else begin
			r.sat = 1'b0;
			r.val = x[DATA_W-1:0];
		end
		return r;
	endfunction

	// Drop the fraction bits of a product sum (half up), then clamp.
	function automatic qau_lane_t round_word(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] half;
		logic signed [ACC_W-1:0] t;
		half = ACC_W'(1) << (FRAC_W - 1);
		t    = x + half;
		t    = t >>> FRAC_W;
		return sat_word(t);
	endfunction

endpackage

// ===== src/qau_fifo.sv =====
// Small first-in first-out queue of flat words with full and empty flags.
// Depends on nothing; used between front and back and at the result side.
module qau_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Storage is payload only.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/qau_front.sv =====
// Front end: decodes the action of a request and routes operands.
// Depends on qau_pkg. Self products (norm, matrix) reuse the Hamilton array with b = a.
module qau_front import qau_pkg::*; (
	input  qau_req_t  request,
	output qau_item_t item
);

	// Decode the action and pick the second operand.
	always_comb begin
		item.a = {request.a_z, request.a_y, request.a_x, request.a_s};
		item.b = {request.b_z, request.b_y, request.b_x, request.b_s};
		case (request.action)
			ACT_ADD:       item.op = OP_ADD;
			ACT_SUB:       item.op = OP_SUB;
			ACT_SCALE:     item.op = OP_SCALE;
			ACT_MUL:       item.op = OP_MUL;
			ACT_NORM2:     item.op = OP_NORM2;
			ACT_NORMALIZE: item.op = OP_NORMALIZE;
			ACT_MATRIX:    item.op = OP_MATRIX;
			default:       item.op = OP_NONE;
		endcase
		if (item.op == OP_NORM2 || item.op == OP_NORMALIZE || item.op == OP_MATRIX) begin
			item.b = item.a;
		end
	end

endmodule

// ===== src/qau_norm.sv =====
// Normalize unit: bit-serial square root of the squared norm, then four
// parallel restoring dividers, one quotient bit per cycle. Depends on qau_pkg.
module qau_norm import qau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NORM_W-1:0]            n_in,
	input  logic [LANES-1:0][DATA_W-1:0] a_in,
	output logic                         busy,
	output logic                         done,
	input  logic                         ack,
	output qau_res_t                     res
);
	localparam int ROOT_STEPS = NORM_W / 2;
	localparam int DIV_STEPS  = FRAC_W + 1;
	localparam int MAX_STEPS  = (ROOT_STEPS > DIV_STEPS) ? ROOT_STEPS : DIV_STEPS;
	localparam int CNT_W      = $clog2(MAX_STEPS);
	localparam int RW         = DATA_W + 4;

	typedef enum logic [1:0] {N_IDLE, N_ROOT, N_DIV, N_DONE} nstate_t;

	nstate_t                 state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [NORM_W-1:0]       nsh_q;
	logic [RW-1:0]           rem_q;
	logic [DATA_W:0]         root_q;
	logic [DATA_W:0]         drem_q [LANES];
	logic [FRAC_W:0]         quo_q [LANES];
	logic [LANES-1:0]        lsb_q;
	logic [LANES-1:0]        neg_q;

	logic [RW-1:0]           rem2;
	logic [RW-1:0]           trial;
	logic [DATA_W+1:0]       drem2 [LANES];
	logic [DATA_W+1:0]       ddiff [LANES];
	logic [DATA_W+1:0]       dsor;
	logic                    first_div;
	logic [DATA_W-1:0]       mag [LANES];
	qau_lane_t               lr [LANES];

	assign busy      = (state_q != N_IDLE);
	assign done      = (state_q == N_DONE);
	assign rem2      = {rem_q[RW-3:0], nsh_q[NORM_W-1:NORM_W-2]};
	assign trial     = RW'({root_q, 2'b01});
	assign dsor      = {1'b0, root_q};
	assign first_div = (cnt_q == CNT_W'(DIV_STEPS - 1));

	// Operand magnitudes and the next partial remainder of each divider.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i]   = a_in[i][DATA_W-1] ? (~a_in[i] + DATA_W'(1)) : a_in[i];
			drem2[i] = {drem_q[i], first_div ? lsb_q[i] : 1'b0};
			ddiff[i] = drem2[i] - dsor;
		end
	end

	// Final rounding, sign and clamping of the quotients.
	always_comb begin
		logic [FRAC_W+1:0]       qf;
		logic signed [ACC_W-1:0] v;
		for (int i = 0; i < LANES; i++) begin
			qf = {1'b0, quo_q[i]} +
				(FRAC_W + 2)'(({drem_q[i], 1'b0} >= dsor) ? 1'b1 : 1'b0);
			v  = ACC_W'(qf);
			if (neg_q[i]) begin
				v = -v;
			end
			lr[i] = sat_word(v);
		end
		res.res_s  = lr[0].val;
		res.res_x  = lr[1].val;
		res.res_y  = lr[2].val;
		res.res_z  = lr[3].val;
		res.status = (lr[0].sat || lr[1].sat || lr[2].sat || lr[3].sat) ? ST_SAT : ST_OK;
		res.last   = 1'b1;
	end

	// Sequencer: square root steps, then division steps, then hold the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			nsh_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			lsb_q   <= '0;
			neg_q   <= '0;
			for (int i = 0; i < LANES; i++) begin
				drem_q[i] <= '0;
				quo_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_ROOT;
						cnt_q   <= CNT_W'(ROOT_STEPS - 1);
						nsh_q   <= n_in;
						rem_q   <= '0;
						root_q  <= '0;
						for (int i = 0; i < LANES; i++) begin
							drem_q[i] <= {2'b00, mag[i][DATA_W-1:1]};
							lsb_q[i]  <= mag[i][0];
							neg_q[i]  <= a_in[i][DATA_W-1];
							quo_q[i]  <= '0;
						end
					end
				end
				N_ROOT: begin
					nsh_q <= nsh_q << 2;
					if (rem2 >= trial) begin
						rem_q  <= rem2 - trial;
						root_q <= {root_q[DATA_W-1:0], 1'b1};
					end else begin
						rem_q  <= rem2;
						root_q <= {root_q[DATA_W-1:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= N_DIV;
						cnt_q   <= CNT_W'(DIV_STEPS - 1);
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				N_DIV: begin
					for (int i = 0; i < LANES; i++) begin
						if (drem2[i] >= dsor) begin
							drem_q[i] <= ddiff[i][DATA_W:0];
							quo_q[i]  <= {quo_q[i][FRAC_W-1:0], 1'b1};
						end else begin
							drem_q[i] <= drem2[i][DATA_W:0];
							quo_q[i]  <= {quo_q[i][FRAC_W-1:0], 1'b0};
						end
					end
					if (cnt_q == '0) begin
						state_q <= N_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				N_DONE: begin
					if (ack) begin
						state_q <= N_IDLE;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

endmodule

// ===== src/qau_back.sv =====
// Back end: sixteen-multiplier product stage, sum/round/clamp of the selected
// terms, matrix row sequencing and the normalize unit. Depends on qau_pkg, qau_norm.
module qau_back import qau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qau_item_t item,
	input  logic      item_valid,
	output logic      item_pop,
	output qau_res_t  res,
	output logic      res_push,
	input  logic      res_full
);
	localparam int NPROD = 16;
	// Operand lanes of each multiplier: Hamilton product terms.
	localparam int MA [NPROD] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 2, 3, 1, 0, 3, 1, 2};
	localparam int MB [NPROD] = '{0, 1, 2, 3, 1, 0, 3, 2, 2, 0, 1, 3, 3, 0, 2, 1};

	logic signed [PROD_W-1:0]     prod [NPROD];
	logic                         v_s1;
	qau_op_t                      op_s1;
	logic [1:0]                   row_s1;
	logic [LANES-1:0][DATA_W-1:0] a_s1;
	logic [LANES-1:0][DATA_W-1:0] b_s1;
	logic signed [PROD_W-1:0]     p_s1 [NPROD];

	logic signed [ACC_W-1:0]      e [NPROD];
	logic signed [ACC_W-1:0]      ea [LANES];
	logic signed [ACC_W-1:0]      eb [LANES];
	logic signed [ACC_W-1:0]      lane [LANES];
	logic signed [ACC_W-1:0]      n_sum;
	logic                         use_round;
	qau_lane_t                    lr [LANES];
	qau_res_t                     s1_res;
	qau_res_t                     norm_res;
	logic                         n_zero;
	logic                         is_normz;
	logic                         norm_busy;
	logic                         norm_done;
	logic                         norm_push;
	logic                         s1_emit;
	logic                         s1_start;
	logic                         s1_done;
	logic                         s1_load;

	// Multiplier array fed from the head of the queue.
	for (genvar k = 0; k < NPROD; k++) begin : g_mul
		assign prod[k] = $signed(item.a[MA[k]]) * $signed(item.b[MB[k]]);
		assign e[k]    = ACC_W'(p_s1[k]);
	end

	for (genvar i = 0; i < LANES; i++) begin : g_ext
		assign ea[i] = ACC_W'($signed(a_s1[i]));
		assign eb[i] = ACC_W'($signed(b_s1[i]));
	end

	assign n_sum = e[0] + e[1] + e[2] + e[3];

	// Select the exact sum for every result lane.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane[i] = '0;
		end
		use_round = 1'b1;
		case (op_s1)
			OP_ADD: begin
				use_round = 1'b0;
				for (int i = 0; i < LANES; i++) begin
					lane[i] = ea[i] + eb[i];
				end
			end
			OP_SUB: begin
				use_round = 1'b0;
				for (int i = 0; i < LANES; i++) begin
					lane[i] = ea[i] - eb[i];
				end
			end
			OP_SCALE: begin
				lane[0] = e[0];
				lane[1] = e[4];
				lane[2] = e[8];
				lane[3] = e[12];
			end
			OP_MUL: begin
				lane[0] = e[0] - e[1] - e[2] - e[3];
				lane[1] = e[4] + e[5] + e[6] - e[7];
				lane[2] = e[8] + e[9] + e[10] - e[11];
				lane[3] = e[12] + e[13] + e[14] - e[15];
			end
			OP_NORM2: begin
				lane[0] = n_sum;
			end
			OP_MATRIX: begin
				// With b = a: ss, xx, yy, zz in 0..3, sx 4, sy 8, sz 12, yz 6, zx 10, xy 14.
				case (row_s1)
					2'd0: begin
						lane[1] = e[0] + e[1] - e[2] - e[3];
						lane[2] = (e[14] - e[12]) <<< 1;
						lane[3] = (e[10] + e[8]) <<< 1;
					end
					2'd1: begin
						lane[1] = (e[14] + e[12]) <<< 1;
						lane[2] = e[0] - e[1] + e[2] - e[3];
						lane[3] = (e[6] - e[4]) <<< 1;
					end
					default: begin
						lane[1] = (e[10] - e[8]) <<< 1;
						lane[2] = (e[6] + e[4]) <<< 1;
						lane[3] = e[0] - e[1] - e[2] + e[3];
					end
				endcase
			end
			default: begin
				use_round = 1'b1;
			end
		endcase
	end

	// Round the product sums, clamp and pack the direct result.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lr[i] = use_round ? round_word(lane[i]) : sat_word(lane[i]);
		end
		s1_res.res_s  = lr[0].val;
		s1_res.res_x  = lr[1].val;
		s1_res.res_y  = lr[2].val;
		s1_res.res_z  = lr[3].val;
		s1_res.status = (lr[0].sat || lr[1].sat || lr[2].sat || lr[3].sat) ? ST_SAT : ST_OK;
		s1_res.last   = (op_s1 != OP_MATRIX) || (row_s1 == ROW_LAST);
		if (op_s1 == OP_NORMALIZE) begin
			s1_res.res_s  = '0;
			s1_res.res_x  = '0;
			s1_res.res_y  = '0;
			s1_res.res_z  = '0;
			s1_res.status = ST_DIV0;
		end
	end

	// Issue control; the normalize unit holds the result port until drained.
	assign n_zero    = (n_sum == '0);
	assign is_normz  = (op_s1 == OP_NORMALIZE) && !n_zero;
	assign norm_push = norm_done && !res_full;
	assign s1_emit   = v_s1 && !norm_busy && !is_normz && !res_full;
	assign s1_start  = v_s1 && !norm_busy && is_normz;
	assign s1_done   = s1_start || (s1_emit && ((op_s1 != OP_MATRIX) || (row_s1 == ROW_LAST)));
	assign s1_load   = item_valid && (!v_s1 || s1_done);
	assign item_pop  = s1_load;
	assign res_push  = norm_push || s1_emit;
	assign res       = norm_done ? norm_res : s1_res;

	// Product stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			row_s1 <= '0;
		end else begin
			if (s1_load) begin
				v_s1   <= 1'b1;
				row_s1 <= '0;
			end else begin
				if (s1_done) begin
					v_s1 <= 1'b0;
				end
				if (s1_emit && (op_s1 == OP_MATRIX) && (row_s1 != ROW_LAST)) begin
					row_s1 <= row_s1 + 2'd1;
				end
			end
		end
	end

	// Product stage payload.
	always_ff @(posedge clk) begin
		if (s1_load) begin
			op_s1 <= item.op;
			a_s1  <= item.a;
			b_s1  <= item.b;
			for (int k = 0; k < NPROD; k++) begin
				p_s1[k] <= prod[k];
			end
		end
	end

	qau_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s1_start),
		.n_in   (n_sum[NORM_W-1:0]),
		.a_in   (a_s1),
		.busy   (norm_busy),
		.done   (norm_done),
		.ack    (norm_push),
		.res    (norm_res)
	);

endmodule

// ===== src/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit: top level joining the decode front, the request
// queue, the back end and the result queue. Depends on qau_pkg and all qau_ modules.
//
// Usage: a request (action, quaternions a and b in signed Q3.28) enters on
// push while full is low. Results leave in request order: the oldest one is
// on result while empty is low and is taken with pop. Add, subtract, scale,
// multiply, squared norm and unknown actions give one result; the rotation
// matrix gives three rows, last set on the third; normalize gives one.
// A direct result passes the request queue, the product stage and the result queue
// before it shows on result. Throughput: one request per cycle for the direct
// actions and one row per cycle for the matrix, while the result queue has room
// and no normalize is running. Normalize occupies the shared square root and
// divider unit for a 33-step root and a 29-step divide at Q3.28, while later
// requests wait in the product stage and the queue behind it.
// Reset clears both queues and all control state; no result is pending after.
// When the receiver stops popping, the result queue fills, the back end holds
// its product stage, the request queue fills and full rises; nothing is lost.
module quaternion_arithmetic_unit import qau_pkg::*; #(
	parameter int REQ_DEPTH = 4,
	parameter int RES_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  qau_req_t request,
	input  logic     pop,
	output logic     empty,
	output qau_res_t result
);
	qau_item_t dec_item;
	qau_item_t head_item;
	logic      rq_empty;
	logic      bk_pop;
	qau_res_t  bk_res;
	logic      bk_push;
	logic      ob_full;
	logic [$bits(qau_item_t)-1:0] head_bits;
	logic [$bits(qau_res_t)-1:0]  out_bits;

	qau_front u_front (
		.request (request),
		.item    (dec_item)
	);

	qau_fifo #(
		.WIDTH ($bits(qau_item_t)),
		.DEPTH (REQ_DEPTH)
	) u_req_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (dec_item),
		.full    (full),
		.rd_en   (bk_pop),
		.rd_data (head_bits),
		.empty   (rq_empty)
	);

	assign head_item = qau_item_t'(head_bits);

	qau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (head_item),
		.item_valid (!rq_empty),
		.item_pop   (bk_pop),
		.res        (bk_res),
		.res_push   (bk_push),
		.res_full   (ob_full)
	);

	qau_fifo #(
		.WIDTH ($bits(qau_res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bk_push),
		.wr_data (bk_res),
		.full    (ob_full),
		.rd_en   (pop),
		.rd_data (out_bits),
		.empty   (empty)
	);

	assign result = qau_res_t'(out_bits);

	// The back end never offers a result to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) bk_push |-> !ob_full)
		else $error("result pushed into a full queue");

	// The back end only takes a request that is waiting.
	assert property (@(posedge clk) disable iff (!arst_n) bk_pop |-> !rq_empty)
		else $error("request popped from an empty queue");

	// A zero-norm normalize result carries all-zero components.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_DIV0) |->
		(result.res_s == '0 && result.res_x == '0 && result.res_y == '0 &&
		 result.res_z == '0 && result.last))
		else $error("divide-by-zero result with nonzero payload");

	// Status carries only defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == ST_OK || result.status == ST_SAT ||
			result.status == ST_DIV0))
		else $error("undefined status code");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the quaternion arithmetic unit: directed and random requests, each checked
// against a fixed-point predictor of add, sub, scale, product, norm, normalize and matrix, or a typed-in result.
// Depends on qau_pkg and quaternion_arithmetic_unit.
module testbench;
	import qau_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 140;
	localparam int N_DIRECTED  = 20;

	typedef logic signed [191:0] wide_t;

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	qau_req_t request;
	logic     pop;
	logic     empty;
	qau_res_t result;

	qau_res_t expected_results[$];
	int       failures;
	int       cycles;
	bit       quiet_stretch;

	quaternion_arithmetic_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.pop(pop), .empty(empty), .result(result)
	);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Round a wide value by dropping shift bits (half up), then clamp to a data word.
	function automatic qword_t clamp_word(input wide_t x, input int shift, inout bit sat);
		wide_t hi;
		wide_t lo;
		wide_t t;
		hi = (wide_t'(1) <<< (DATA_W - 1)) - 1;
		lo = -hi - 1;
		t = x;
		if (shift > 0)
			t = (t + (wide_t'(1) <<< (shift - 1))) >>> shift;
		if (t > hi) begin
			sat = 1'b1;
			t = hi;
		end else if (t < lo) begin
			sat = 1'b1;
			t = lo;
		end
		return t[DATA_W-1:0];
	endfunction

	function automatic wide_t mulw(input qword_t p, input qword_t q);
		wide_t wp;
		wide_t wq;
		wp = p;
		wq = q;
		return wp * wq;
	endfunction

	function automatic wide_t isqrt_wide(input wide_t n);
		wide_t r;
		wide_t b;
		r = 0;
		b = wide_t'(1) <<< 190;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic qau_res_t make_res(input qword_t s, x, y, z, input logic [1:0] st,
			input logic lst);
		qau_res_t r;
		r.res_s = s;
		r.res_x = x;
		r.res_y = y;
		r.res_z = z;
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	// Predict the results of one request and queue them.
	task automatic predict_quaternion(input qau_req_t rq);
		qword_t a[4];
		qword_t b[4];
		wide_t  t[4];
		wide_t  m[9];
		wide_t  n;
		wide_t  root;
		wide_t  mag;
		wide_t  q;
		qword_t r[4];
		bit     sat;
		a = '{rq.a_s, rq.a_x, rq.a_y, rq.a_z};
		b = '{rq.b_s, rq.b_x, rq.b_y, rq.b_z};
		sat = 1'b0;
		case (rq.action)
			ACT_ADD, ACT_SUB: begin
				for (int i = 0; i < 4; i++)
					r[i] = clamp_word(rq.action == ACT_ADD ? wide_t'(a[i]) + wide_t'(b[i])
						: wide_t'(a[i]) - wide_t'(b[i]), 0, sat);
				expected_results.push_back(make_res(r[0], r[1], r[2], r[3], sat ? ST_SAT : ST_OK, 1'b1));
			end
			ACT_SCALE: begin
				for (int i = 0; i < 4; i++)
					r[i] = clamp_word(mulw(a[0], b[i]), FRAC_W, sat);
				expected_results.push_back(make_res(r[0], r[1], r[2], r[3], sat ? ST_SAT : ST_OK, 1'b1));
			end
			ACT_MUL: begin
				t[0] = mulw(a[0], b[0]) - mulw(a[1], b[1]) - mulw(a[2], b[2]) - mulw(a[3], b[3]);
				t[1] = mulw(a[0], b[1]) + mulw(b[0], a[1]) + mulw(a[2], b[3]) - mulw(a[3], b[2]);
				t[2] = mulw(a[0], b[2]) + mulw(b[0], a[2]) + mulw(a[3], b[1]) - mulw(a[1], b[3]);
				t[3] = mulw(a[0], b[3]) + mulw(b[0], a[3]) + mulw(a[1], b[2]) - mulw(a[2], b[1]);
				for (int i = 0; i < 4; i++)
					r[i] = clamp_word(t[i], FRAC_W, sat);
				expected_results.push_back(make_res(r[0], r[1], r[2], r[3], sat ? ST_SAT : ST_OK, 1'b1));
			end
			ACT_NORM2, ACT_NORMALIZE: begin
				n = 0;
				for (int i = 0; i < 4; i++)
					n = n + mulw(a[i], a[i]);
				if (rq.action == ACT_NORM2) begin
					r[0] = clamp_word(n, FRAC_W, sat);
					expected_results.push_back(make_res(r[0], 0, 0, 0, sat ? ST_SAT : ST_OK, 1'b1));
				end else if (n == 0) begin
					expected_results.push_back(make_res(0, 0, 0, 0, ST_DIV0, 1'b1));
				end else begin
					root = isqrt_wide(n);
					for (int i = 0; i < 4; i++) begin
						mag = a[i] < 0 ? -wide_t'(a[i]) : wide_t'(a[i]);
						mag = mag <<< FRAC_W;
						q = mag / root;
						if (2 * (mag % root) >= root)
							q = q + 1;
						r[i] = clamp_word(a[i] < 0 ? -q : q, 0, sat);
					end
					expected_results.push_back(make_res(r[0], r[1], r[2], r[3], sat ? ST_SAT : ST_OK, 1'b1));
				end
			end
			ACT_MATRIX: begin
				m[0] = mulw(a[0], a[0]) + mulw(a[1], a[1]) - mulw(a[2], a[2]) - mulw(a[3], a[3]);
				m[1] = 2 * (mulw(a[1], a[2]) - mulw(a[0], a[3]));
				m[2] = 2 * (mulw(a[1], a[3]) + mulw(a[0], a[2]));
				m[3] = 2 * (mulw(a[1], a[2]) + mulw(a[0], a[3]));
				m[4] = mulw(a[0], a[0]) - mulw(a[1], a[1]) + mulw(a[2], a[2]) - mulw(a[3], a[3]);
				m[5] = 2 * (mulw(a[2], a[3]) - mulw(a[0], a[1]));
				m[6] = 2 * (mulw(a[1], a[3]) - mulw(a[0], a[2]));
				m[7] = 2 * (mulw(a[2], a[3]) + mulw(a[0], a[1]));
				m[8] = mulw(a[0], a[0]) - mulw(a[1], a[1]) - mulw(a[2], a[2]) + mulw(a[3], a[3]);
				for (int row = 0; row < 3; row++) begin
					sat = 1'b0;
					for (int i = 0; i < 3; i++)
						r[i] = clamp_word(m[row * 3 + i], FRAC_W, sat);
					expected_results.push_back(make_res(0, r[0], r[1], r[2], sat ? ST_SAT : ST_OK,
						row == 2));
				end
			end
			default: expected_results.push_back(make_res(0, 0, 0, 0, ST_OK, 1'b1));
		endcase
	endtask

	localparam qword_t Q_MAX = 32'sh7fffffff;
	localparam qword_t Q_MIN = 32'sh80000000;
	localparam qword_t Q_ONE = 32'sh10000000;

	// Directed rows; check_now marks rows whose result is typed in here.
	typedef struct {
		qau_req_t rq;
		bit       check_now;
		qau_res_t want;
	} stim_row_t;

	function automatic qau_req_t mk_req(input logic [2:0] act, input qword_t as, ax, ay, az,
			input qword_t bs, bx, by, bz);
		qau_req_t r;
		r = '{act, as, ax, ay, az, bs, bx, by, bz};
		return r;
	endfunction

	function automatic qword_t rand_word();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return qword_t'($urandom_range(0, 1) ? Q_ONE : -Q_ONE);
			3: return qword_t'($signed($urandom_range(0, 32'h1fffffff)) - 32'sh10000000);
			default: return qword_t'($urandom);
		endcase
	endfunction

	// Push one request: present it at a falling edge and hold it until accepted.
	task automatic send_request(input qau_req_t rq);
		request <= rq;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		predict_quaternion(rq);
		@(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!quiet_stretch && $urandom_range(0, 99) < 32) begin
			push <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Result side: random pop, compare each accepted result with the oldest expectation.
	always @(negedge clk)
		pop <= arst_n && (quiet_stretch || $urandom_range(0, 99) >= 32);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result %p", result);
				failures++;
			end else begin
				qau_res_t w;
				w = expected_results.pop_front();
				if (result.res_s !== w.res_s) begin
					$error("res_s expected %0d actual %0d", w.res_s, result.res_s);
					failures++;
				end
				if (result.res_x !== w.res_x) begin
					$error("res_x expected %0d actual %0d", w.res_x, result.res_x);
					failures++;
				end
				if (result.res_y !== w.res_y) begin
					$error("res_y expected %0d actual %0d", w.res_y, result.res_y);
					failures++;
				end
				if (result.res_z !== w.res_z) begin
					$error("res_z expected %0d actual %0d", w.res_z, result.res_z);
					failures++;
				end
				if (result.status !== w.status) begin
					$error("status expected %0d actual %0d", w.status, result.status);
					failures++;
				end
				if (result.last !== w.last) begin
					$error("last expected %0d actual %0d", w.last, result.last);
					failures++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		stim_row_t rows[N_DIRECTED];
		qau_req_t  rq;
		failures = 0;
		cycles = 0;
		quiet_stretch = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		request = '0;
		rows[0]  = '{mk_req(ACT_ADD, Q_MAX, Q_MIN, 1, -1, 1, -1, 1, -1), 1'b1,
			make_res(Q_MAX, Q_MIN, 2, -2, ST_SAT, 1'b1)};
		rows[1]  = '{mk_req(ACT_SUB, Q_MIN, Q_MAX, 0, 0, 1, -1, 0, 0), 1'b1,
			make_res(Q_MIN, Q_MAX, 0, 0, ST_SAT, 1'b1)};
		rows[2]  = '{mk_req(ACT_SCALE, Q_ONE, 0, 0, 0, Q_MAX, Q_MIN, 5, -5), 1'b1,
			make_res(Q_MAX, Q_MIN, 5, -5, ST_OK, 1'b1)};
		rows[3]  = '{mk_req(ACT_SCALE, Q_MAX, 0, 0, 0, Q_MAX, Q_MIN, 0, 0), 1'b0, '0};
		rows[4]  = '{mk_req(ACT_MUL, Q_ONE, 0, 0, 0, 1, 2, 3, 4), 1'b1,
			make_res(1, 2, 3, 4, ST_OK, 1'b1)};
		rows[5]  = '{mk_req(ACT_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN),
			1'b0, '0};
		rows[6]  = '{mk_req(ACT_NORM2, Q_ONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			make_res(Q_ONE, 0, 0, 0, ST_OK, 1'b1)};
		rows[7]  = '{mk_req(ACT_NORM2, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0), 1'b1,
			make_res(Q_MAX, 0, 0, 0, ST_SAT, 1'b1)};
		rows[8]  = '{mk_req(ACT_NORMALIZE, 0, 0, 0, 0, -1, -1, -1, -1), 1'b1,
			make_res(0, 0, 0, 0, ST_DIV0, 1'b1)};
		rows[9]  = '{mk_req(ACT_NORMALIZE, Q_ONE * 2, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			make_res(Q_ONE, 0, 0, 0, ST_OK, 1'b1)};
		rows[10] = '{mk_req(ACT_NORMALIZE, Q_MIN, Q_MAX, -3, 1, 0, 0, 0, 0), 1'b0, '0};
		rows[11] = '{mk_req(ACT_NORMALIZE, 0, 0, 0, 1, 0, 0, 0, 0), 1'b0, '0};
		rows[12] = '{mk_req(ACT_MATRIX, Q_ONE, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		rows[13] = '{mk_req(ACT_MATRIX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 0), 1'b0, '0};
		rows[14] = '{mk_req(ACT_MATRIX, 0, 0, 0, 0, 7, 7, 7, 7), 1'b0, '0};
		rows[15] = '{mk_req(OP_NONE, Q_MAX, Q_MIN, 1, 1, 1, 1, 1, 1), 1'b1,
			make_res(0, 0, 0, 0, ST_OK, 1'b1)};
		rows[16] = '{mk_req(ACT_MUL, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2,
			Q_ONE / 2, -Q_ONE / 2, -Q_ONE / 2, -Q_ONE / 2), 1'b0, '0};
		rows[17] = '{mk_req(ACT_ADD, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1,
			make_res(-2, -2, -2, -2, ST_OK, 1'b1)};
		rows[18] = '{mk_req(ACT_SCALE, Q_MIN, 0, 0, 0, Q_MIN, 1, 0, 0), 1'b0, '0};
		rows[19] = '{mk_req(ACT_SUB, 0, 0, 0, 0, Q_MIN, 0, 0, 0), 1'b1,
			make_res(Q_MAX, 0, 0, 0, ST_SAT, 1'b1)};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; a typed-in result replaces the one just predicted, which is
		// still the newest entry since no result leaves that soon after its request.
		foreach (rows[i]) begin
			send_request(rows[i].rq);
			if (rows[i].check_now)
				expected_results[expected_results.size() - 1] = rows[i].want;
			maybe_idle();
		end
		push <= 1'b0;

		// Hold the sender until every expected result has drained.
		while (expected_results.size() != 0)
			@(negedge clk);

		// Random requests, with a stretch of back-to-back traffic in the middle.
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_stretch = (i >= 60 && i < 100);
			rq.action = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(0, 6));
			if ($urandom_range(0, 19) == 0)
				rq.action = ACT_NORMALIZE;
			rq.a_s = rand_word();
			rq.a_x = rand_word();
			rq.a_y = rand_word();
			rq.a_z = rand_word();
			rq.b_s = rand_word();
			rq.b_x = rand_word();
			rq.b_y = rand_word();
			rq.b_z = rand_word();
			if (rq.action == ACT_NORMALIZE && $urandom_range(0, 7) == 0)
				{rq.a_s, rq.a_x, rq.a_y, rq.a_z} = '0;
			send_request(rq);
			maybe_idle();
		end
		push <= 1'b0;
		quiet_stretch = 1'b0;

		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (100) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
